// ----- sv/spms_pkg.sv -----
// Package with shared widths, codes, state type and defaults for the shared-pool stack block.
package spms_pkg;

  localparam int OPCODE_W   = 1;
  localparam int STACK_ID_W = 2;
  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;

  localparam int NUM_STACKS_DEF = 4;
  localparam int POOL_DEPTH_DEF = 64;

  localparam logic [OPCODE_W-1:0] OP_PUSH = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_POP
  } state_t;

endpackage

// ----- sv/spms_if.sv -----
// Valid/ready channel interfaces for request words and result words.
interface spms_in_if;
  import spms_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [STACK_ID_W-1:0] stack_id;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output opcode, output stack_id, output push_value,
                  input ready);
  modport sink   (input valid, input opcode, input stack_id, input push_value,
                  output ready);
endinterface

interface spms_out_if;
  import spms_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic signed [DATA_W-1:0] pop_value;

  modport source (output valid, output status, output pop_value, input ready);
  modport sink   (input valid, input status, input pop_value, output ready);
endinterface

// ----- sv/shared_pool_multi_stack.sv -----
// Top level of the shared-pool multi-stack: sequencer, value and top-pointer memories.
//
// NUM_STACKS LIFO stacks share one pool of POOL_DEPTH entries. Each request word
// either pushes push_value onto stack stack_id or pops that stack, and each gives
// exactly one result word with a status (ok, overflow on push, underflow on pop)
// and the popped value, which is zero unless a pop succeeds. A push on an
// exhausted pool or a stack number at or above NUM_STACKS reports overflow; a pop
// of an empty or nonexistent stack reports underflow; neither changes any state.
// One request is worked at a time. A push or a failed pop writes its result
// word into the output register from the look state, and a successful pop
// does so from the pop state; the input is ready again once the sequencer is
// back in idle. This order is set by the registered reads of the memories:
// the stack top is read first, and a pop then needs a second read of that
// entry's link and value before the pointers can be written back. A finished
// result sits in an output register, so the next request is accepted while it
// waits to be taken; the block only stalls when a second result is ready
// before the first one has left. No clearing pass is needed after reset: the
// link memory uses a fill count and the stack tops carry valid bits, so the
// block is ready at once.
module shared_pool_multi_stack #(
  parameter int NUM_STACKS = spms_pkg::NUM_STACKS_DEF,
  parameter int POOL_DEPTH = spms_pkg::POOL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  spms_in_if.sink    in_ch,
  spms_out_if.source out_ch
);
  import spms_pkg::*;

  localparam int LINK_W    = $clog2(POOL_DEPTH + 1);
  localparam int ENTRY_AW  = $clog2(POOL_DEPTH);
  localparam int TOP_AW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int SID_EXT_W = (TOP_AW > STACK_ID_W) ? TOP_AW : STACK_ID_W;
  localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(POOL_DEPTH);

  // Sequencer state and the captured request.
  state_t              state_r, state_nxt;
  logic [OPCODE_W-1:0] op_r;
  logic [TOP_AW-1:0]   idx_r;
  logic                id_ok_r;
  logic [DATA_W-1:0]   val_r;

  // Pointer state. The free head lives in a register; the stack tops live in
  // a small memory whose entries read as null until first written.
  logic [LINK_W-1:0]     free_head_r, free_head_nxt;
  logic [LINK_W-1:0]     tops_mem [NUM_STACKS];
  logic [NUM_STACKS-1:0] tops_vld_r;
  logic [LINK_W-1:0]     top_rd_r;
  logic                  top_vld_r;
  logic [LINK_W-1:0]     top_eff;

  // Entry values. Only entries that a push wrote are ever read back.
  logic [DATA_W-1:0] vals_mem [POOL_DEPTH];
  logic [DATA_W-1:0] vals_rd_r;

  // Result register.
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [DATA_W-1:0]   out_pop_value_r, out_pop_value_nxt;

  // Request decode.
  logic                 in_acc;
  logic                 out_free;
  logic                 sid_ok;
  logic [SID_EXT_W-1:0] sid_ext;
  logic [TOP_AW-1:0]    in_idx;

  // Memory control.
  logic              link_rd_en;
  logic [LINK_W-1:0] link_rd_addr;
  logic [LINK_W-1:0] link_rd_data;
  logic              link_wr_en;
  logic [LINK_W-1:0] link_wr_addr;
  logic [LINK_W-1:0] link_wr_data;
  logic              tops_we;
  logic [LINK_W-1:0] tops_wdata;
  logic              vals_we;
  logic              vals_re;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign sid_ext = SID_EXT_W'(in_ch.stack_id);
  assign in_idx  = sid_ext[TOP_AW-1:0];
  assign sid_ok  = 32'(in_ch.stack_id) < 32'(NUM_STACKS);

  assign top_eff = top_vld_r ? top_rd_r : LINK_NULL;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.pop_value = out_pop_value_r;

  spms_link_store #(
    .POOL_DEPTH (POOL_DEPTH),
    .LINK_W     (LINK_W)
  ) u_links (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (link_rd_en),
    .rd_addr (link_rd_addr),
    .rd_data (link_rd_data),
    .wr_en   (link_wr_en),
    .wr_addr (link_wr_addr),
    .wr_data (link_wr_data)
  );

  // Next state, memory control and result. Reads and write-backs of the same
  // entry never fall in one cycle: each item finishes its writes before the
  // next one is accepted and issues its first read.
  always_comb begin
    state_nxt         = state_r;
    free_head_nxt     = free_head_r;
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_status_nxt    = out_status_r;
    out_pop_value_nxt = out_pop_value_r;
    link_rd_en        = 1'b0;
    link_rd_addr      = free_head_r;
    link_wr_en        = 1'b0;
    link_wr_addr      = free_head_r;
    link_wr_data      = top_eff;
    tops_we           = 1'b0;
    tops_wdata        = free_head_r;
    vals_we           = 1'b0;
    vals_re           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          // The free head's link is fetched now in case this is a push.
          link_rd_en = 1'b1;
          state_nxt  = S_LOOK;
        end
      end
      S_LOOK: begin
        if (op_r == OP_PUSH) begin
          if (out_free) begin
            out_valid_nxt     = 1'b1;
            out_pop_value_nxt = '0;
            if (!id_ok_r || (free_head_r == LINK_NULL)) begin
              out_status_nxt = ST_OVERFLOW;
            end else begin
              out_status_nxt = ST_OK;
              vals_we        = 1'b1;
              link_wr_en     = 1'b1;
              tops_we        = 1'b1;
              free_head_nxt  = link_rd_data;
            end
            state_nxt = S_IDLE;
          end
        end else if (!id_ok_r || (top_eff == LINK_NULL)) begin
          if (out_free) begin
            out_valid_nxt     = 1'b1;
            out_status_nxt    = ST_UNDERFLOW;
            out_pop_value_nxt = '0;
            state_nxt         = S_IDLE;
          end
        end else begin
          link_rd_en   = 1'b1;
          link_rd_addr = top_eff;
          vals_re      = 1'b1;
          state_nxt    = S_POP;
        end
      end
      S_POP: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_status_nxt    = ST_OK;
          out_pop_value_nxt = vals_rd_r;
          tops_we           = 1'b1;
          tops_wdata        = link_rd_data;
          link_wr_en        = 1'b1;
          link_wr_addr      = top_eff;
          link_wr_data      = free_head_r;
          free_head_nxt     = top_eff;
          state_nxt         = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      tops_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
      if (tops_we) begin
        tops_vld_r[idx_r] <= 1'b1;
      end
    end
  end

  // Captured request and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_ch.opcode;
      idx_r   <= in_idx;
      id_ok_r <= sid_ok;
      val_r   <= in_ch.push_value;
    end
    out_status_r    <= out_status_nxt;
    out_pop_value_r <= out_pop_value_nxt;
  end

  // Stack top memory: read at acceptance, written when an item commits.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      top_rd_r  <= tops_mem[in_idx];
      top_vld_r <= tops_vld_r[in_idx];
    end
    if (tops_we) begin
      tops_mem[idx_r] <= tops_wdata;
    end
  end

  // Value memory: written by a push at the free head, read by a pop at the top.
  always_ff @(posedge clk) begin
    if (vals_re) begin
      vals_rd_r <= vals_mem[top_eff[ENTRY_AW-1:0]];
    end
    if (vals_we) begin
      vals_mem[free_head_r[ENTRY_AW-1:0]] <= val_r;
    end
  end

endmodule

// ----- sv/spms_link_store.sv -----
// Link memory of the entry pool, with a fill count standing in for its reset pattern.
module spms_link_store #(
  parameter int POOL_DEPTH = spms_pkg::POOL_DEPTH_DEF,
  parameter int LINK_W     = $clog2(POOL_DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [LINK_W-1:0] rd_addr,
  output logic [LINK_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [LINK_W-1:0] wr_addr,
  input  logic [LINK_W-1:0] wr_data
);
  import spms_pkg::*;

  localparam int ENTRY_AW = $clog2(POOL_DEPTH);

  logic [LINK_W-1:0] mem [POOL_DEPTH];
  logic [LINK_W-1:0] mem_q_r;
  logic [LINK_W-1:0] addr_r;
  logic              hit_r;
  logic [LINK_W-1:0] fill_r;
  logic [LINK_W-1:0] fill_nxt;

  // Entries at or above the fill count were never written and still hold
  // their reset link, which is simply the next index (null after the last).
  assign rd_data = hit_r ? mem_q_r : addr_r + LINK_W'(1);

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && (wr_addr >= fill_r)) begin
      fill_nxt = fill_r + LINK_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr[ENTRY_AW-1:0]];
      addr_r  <= rd_addr;
      hit_r   <= rd_addr < fill_r;
    end
    if (wr_en) begin
      mem[wr_addr[ENTRY_AW-1:0]] <= wr_data;
    end
  end

endmodule

// ----- sv/spms_checker.sv -----
// Port-level checker for the shared-pool multi-stack, bound to its top level.
module spms_props (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic [spms_pkg::OPCODE_W-1:0]  in_opcode,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [spms_pkg::STATUS_W-1:0]  out_status,
  input logic [spms_pkg::DATA_W-1:0]    out_pop_value
);
  import spms_pkg::*;

  logic                in_acc;
  logic                out_acc;
  logic [1:0]          cnt_r;
  logic [OPCODE_W-1:0] op_q_r [2];

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Opcodes of the words still owed a result, oldest first.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_r + 2'(in_acc) - 2'(out_acc);
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      if (in_acc && (cnt_r == 2'd1)) begin
        op_q_r[0] <= in_opcode;
      end else begin
        op_q_r[0] <= op_q_r[1];
      end
      if (in_acc && (cnt_r != 2'd1)) begin
        op_q_r[1] <= in_opcode;
      end
    end else if (in_acc) begin
      if (cnt_r == 2'd0) begin
        op_q_r[0] <= in_opcode;
      end else begin
        op_q_r[1] <= in_opcode;
      end
    end
  end

  a_overflow_on_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OVERFLOW) |-> (op_q_r[0] == OP_PUSH))
    else $error("overflow reported for a pop");

  a_underflow_on_pop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_UNDERFLOW) |-> (op_q_r[0] == OP_POP))
    else $error("underflow reported for a push");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && ((out_status != ST_OK) || (op_q_r[0] == OP_PUSH))
      |-> (out_pop_value == '0))
    else $error("nonzero value on a push or failed pop");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second word accepted while one is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_pop_value))
    else $error("stalled result word changed");

endmodule

bind shared_pool_multi_stack spms_props u_spms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .in_opcode     (in_ch.opcode),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_pop_value (out_ch.pop_value)
);
